// File: src/clu_pkg.sv
// ----------------------------------------------------------------------------
// clu_pkg
// Shared types, opcodes and helper functions of the load instruction unit.
// ----------------------------------------------------------------------------
package clu_pkg;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_READ    = 2'd1;
    localparam logic [1:0] STATUS_UNKNOWN = 2'd2;
    localparam logic [1:0] STATUS_SEQ     = 2'd3;

    localparam logic CMD_EXEC = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam logic [2:0] REG_B   = 3'd0;
    localparam logic [2:0] REG_C   = 3'd1;
    localparam logic [2:0] REG_D   = 3'd2;
    localparam logic [2:0] REG_E   = 3'd3;
    localparam logic [2:0] REG_H   = 3'd4;
    localparam logic [2:0] REG_L   = 3'd5;
    localparam logic [2:0] REG_MEM = 3'd6;
    localparam logic [2:0] REG_A   = 3'd7;

    localparam logic [7:0] OP_HALT     = 8'h76;
    localparam logic [7:0] OP_LD_BC_A  = 8'h02;
    localparam logic [7:0] OP_LD_DE_A  = 8'h12;
    localparam logic [7:0] OP_LDI_HL_A = 8'h22;
    localparam logic [7:0] OP_LDD_HL_A = 8'h32;
    localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
    localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
    localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
    localparam logic [7:0] OP_LDD_A_HL = 8'h3A;
    localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
    localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
    localparam logic [7:0] OP_LD_C_A   = 8'hE2;
    localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
    localparam logic [7:0] OP_LD_HL_N  = 8'h36;
    localparam logic [7:0] OP_LD_B_N   = 8'h06;
    localparam logic [7:0] OP_LD_C_N   = 8'h0E;
    localparam logic [7:0] OP_LD_A_N   = 8'h3E;
    localparam logic [7:0] OP_LD_BC_NN = 8'h01;
    localparam logic [7:0] OP_LD_HL_NN = 8'h21;
    localparam logic [7:0] OP_LD_SP_NN = 8'h31;

    localparam logic [1:0] OP_GRP_MOVE = 2'b01;
    localparam logic [7:0] HIGH_PAGE   = 8'hFF;

    localparam logic [4:0] CYC_NONE = 5'd0;
    localparam logic [4:0] CYC_4    = 5'd4;
    localparam logic [4:0] CYC_8    = 5'd8;
    localparam logic [4:0] CYC_12   = 5'd12;
    localparam logic [4:0] CYC_16   = 5'd16;

    typedef struct packed {
        logic       command;
        logic [7:0] opcode;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] read_data;
    } clu_item_t;

    typedef struct packed {
        logic [7:0]  a;
        logic [7:0]  b;
        logic [7:0]  c;
        logic [7:0]  d;
        logic [7:0]  e;
        logic [7:0]  h;
        logic [7:0]  l;
        logic [15:0] sp;
        logic        pending;
        logic [2:0]  dest;
    } clu_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  cycles;
        logic        bus_valid;
        logic        bus_write;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
    } clu_result_t;

    function automatic logic [7:0] read_reg(clu_state_t st, logic [2:0] code);
        logic [7:0] v;
        case (code)
            REG_B:   v = st.b;
            REG_C:   v = st.c;
            REG_D:   v = st.d;
            REG_E:   v = st.e;
            REG_H:   v = st.h;
            REG_L:   v = st.l;
            REG_A:   v = st.a;
            default: v = 8'd0;
        endcase
        return v;
    endfunction

    function automatic clu_state_t write_reg(clu_state_t st, logic [2:0] code,
                                             logic [7:0] v);
        clu_state_t r;
        r = st;
        case (code)
            REG_B:   r.b = v;
            REG_C:   r.c = v;
            REG_D:   r.d = v;
            REG_E:   r.e = v;
            REG_H:   r.h = v;
            REG_L:   r.l = v;
            REG_A:   r.a = v;
            default: r = st;
        endcase
        return r;
    endfunction

endpackage

// File: src/cpu_load_instruction_unit.sv
// ----------------------------------------------------------------------------
// cpu_load_instruction_unit
// Load subset execute unit of an 8-bit CPU with bus access reporting.
// ----------------------------------------------------------------------------
// An instruction or read-data transfer is taken into an input register, then
// decoded and executed combinationally against the register file, and its
// result lands in an output register together with the register values after
// it. The unit sustains one transfer per clock unless the output is stalled.
// The rate is set by the single register file update per cycle,
// which every item passes through in order. A load from memory returns status
// read issued with the bus read; the data comes back as a later transfer with
// command set, and any other item in between is answered out of sequence.
module cpu_load_instruction_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_opcode,
    input  logic [7:0]  s_imm_low,
    input  logic [7:0]  s_imm_high,
    input  logic [7:0]  s_read_data,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [4:0]  m_cycle_count,
    output logic        m_bus_valid,
    output logic        m_bus_write,
    output logic [15:0] m_bus_address,
    output logic [7:0]  m_bus_data,
    output logic [7:0]  m_value_a,
    output logic [15:0] m_value_bc,
    output logic [15:0] m_value_de,
    output logic [15:0] m_value_hl,
    output logic [15:0] m_value_sp
);
    import clu_pkg::*;

    logic        in_valid_reg;
    clu_item_t   in_item_reg;
    logic        out_valid_reg;
    clu_result_t out_res_reg;
    clu_state_t  out_state_reg;

    clu_state_t  state;
    clu_state_t  state_next;
    clu_result_t result;
    logic        advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= '{command:   s_command,
                             opcode:    s_opcode,
                             imm_low:   s_imm_low,
                             imm_high:  s_imm_high,
                             read_data: s_read_data};
        end
    end

    clu_regfile u_regfile (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .update     (advance),
        .state_next (state_next),
        .state      (state)
    );

    clu_exec u_exec (
        .item       (in_item_reg),
        .state      (state),
        .state_next (state_next),
        .result     (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg   <= result;
            out_state_reg <= state_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_res_reg.status;
    assign m_cycle_count = out_res_reg.cycles;
    assign m_bus_valid   = out_res_reg.bus_valid;
    assign m_bus_write   = out_res_reg.bus_write;
    assign m_bus_address = out_res_reg.bus_address;
    assign m_bus_data    = out_res_reg.bus_data;
    assign m_value_a     = out_state_reg.a;
    assign m_value_bc    = {out_state_reg.b, out_state_reg.c};
    assign m_value_de    = {out_state_reg.d, out_state_reg.e};
    assign m_value_hl    = {out_state_reg.h, out_state_reg.l};
    assign m_value_sp    = out_state_reg.sp;

`ifndef SYNTHESIS
    a_read_is_bus_read: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_READ |-> m_bus_valid && !m_bus_write
                                               && m_bus_data == 8'd0)
        else $error("read result without bus read");

    a_no_access_on_reject: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_UNKNOWN || m_status == STATUS_SEQ)
            |-> m_cycle_count == CYC_NONE && !m_bus_valid)
        else $error("rejected item carries an access");

    a_pending_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && result.status == STATUS_READ |=> state.pending)
        else $error("read issued but no load pending");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// File: src/clu_exec.sv
// ----------------------------------------------------------------------------
// clu_exec
// Decode and execute of one item: next register state and bus result.
// ----------------------------------------------------------------------------
module clu_exec (
    input  clu_pkg::clu_item_t   item,
    input  clu_pkg::clu_state_t  state,
    output clu_pkg::clu_state_t  state_next,
    output clu_pkg::clu_result_t result
);
    import clu_pkg::*;

    logic [15:0] hl;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] imm16;
    logic [2:0]  dst;
    logic [2:0]  src;
    logic        rd_issue;
    logic [2:0]  rd_dest;

    assign hl    = {state.h, state.l};
    assign bc    = {state.b, state.c};
    assign de    = {state.d, state.e};
    assign imm16 = {item.imm_high, item.imm_low};
    assign dst   = item.opcode[5:3];
    assign src   = item.opcode[2:0];

    always_comb begin
        state_next = state;
        result     = '0;
        rd_issue   = 1'b0;
        rd_dest    = REG_A;

        if (item.command == CMD_DATA) begin
            if (state.pending) begin
                state_next         = write_reg(state, state.dest, item.read_data);
                state_next.pending = 1'b0;
            end else begin
                result.status = STATUS_SEQ;
            end
        end else if (state.pending) begin
            result.status = STATUS_SEQ;
        end else if (item.opcode[7:6] == OP_GRP_MOVE && item.opcode != OP_HALT) begin
            if (dst == REG_MEM) begin
                result.bus_valid   = 1'b1;
                result.bus_write   = 1'b1;
                result.bus_address = hl;
                result.bus_data    = read_reg(state, src);
                result.cycles      = CYC_8;
            end else if (src == REG_MEM) begin
                rd_issue           = 1'b1;
                rd_dest            = dst;
                result.bus_address = hl;
                result.cycles      = CYC_8;
            end else begin
                state_next    = write_reg(state, dst, read_reg(state, src));
                result.cycles = CYC_4;
            end
        end else begin
            case (item.opcode)
                OP_LD_BC_A, OP_LD_DE_A, OP_LDI_HL_A, OP_LDD_HL_A: begin
                    result.bus_valid = 1'b1;
                    result.bus_write = 1'b1;
                    result.bus_data  = state.a;
                    result.cycles    = CYC_8;
                    if (item.opcode == OP_LD_BC_A) begin
                        result.bus_address = bc;
                    end else if (item.opcode == OP_LD_DE_A) begin
                        result.bus_address = de;
                    end else begin
                        result.bus_address = hl;
                    end
                    if (item.opcode == OP_LDI_HL_A) begin
                        {state_next.h, state_next.l} = hl + 16'd1;
                    end else if (item.opcode == OP_LDD_HL_A) begin
                        {state_next.h, state_next.l} = hl - 16'd1;
                    end
                end
                OP_LD_A_BC, OP_LD_A_DE, OP_LDI_A_HL, OP_LDD_A_HL: begin
                    rd_issue      = 1'b1;
                    result.cycles = CYC_8;
                    if (item.opcode == OP_LD_A_BC) begin
                        result.bus_address = bc;
                    end else if (item.opcode == OP_LD_A_DE) begin
                        result.bus_address = de;
                    end else begin
                        result.bus_address = hl;
                    end
                    if (item.opcode == OP_LDI_A_HL) begin
                        {state_next.h, state_next.l} = hl + 16'd1;
                    end else if (item.opcode == OP_LDD_A_HL) begin
                        {state_next.h, state_next.l} = hl - 16'd1;
                    end
                end
                OP_LDH_A_N: begin
                    rd_issue           = 1'b1;
                    result.bus_address = {HIGH_PAGE, item.imm_low};
                    result.cycles      = CYC_12;
                end
                OP_LDH_N_A: begin
                    result.bus_valid   = 1'b1;
                    result.bus_write   = 1'b1;
                    result.bus_address = {HIGH_PAGE, item.imm_low};
                    result.bus_data    = state.a;
                    result.cycles      = CYC_12;
                end
                OP_LD_C_A: begin
                    result.bus_valid   = 1'b1;
                    result.bus_write   = 1'b1;
                    result.bus_address = {HIGH_PAGE, state.c};
                    result.bus_data    = state.a;
                    result.cycles      = CYC_8;
                end
                OP_LD_NN_A: begin
                    result.bus_valid   = 1'b1;
                    result.bus_write   = 1'b1;
                    result.bus_address = imm16;
                    result.bus_data    = state.a;
                    result.cycles      = CYC_16;
                end
                OP_LD_HL_N: begin
                    result.bus_valid   = 1'b1;
                    result.bus_write   = 1'b1;
                    result.bus_address = hl;
                    result.bus_data    = item.imm_low;
                    result.cycles      = CYC_12;
                end
                OP_LD_B_N: begin
                    state_next.b  = item.imm_low;
                    result.cycles = CYC_8;
                end
                OP_LD_C_N: begin
                    state_next.c  = item.imm_low;
                    result.cycles = CYC_8;
                end
                OP_LD_A_N: begin
                    state_next.a  = item.imm_low;
                    result.cycles = CYC_8;
                end
                OP_LD_BC_NN: begin
                    {state_next.b, state_next.c} = imm16;
                    result.cycles                = CYC_12;
                end
                OP_LD_HL_NN: begin
                    {state_next.h, state_next.l} = imm16;
                    result.cycles                = CYC_12;
                end
                OP_LD_SP_NN: begin
                    state_next.sp = imm16;
                    result.cycles = CYC_12;
                end
                default: begin
                    result.status = STATUS_UNKNOWN;
                    result.cycles = CYC_NONE;
                end
            endcase
        end

        // read issue: bus read and load target recorded
        if (rd_issue) begin
            result.bus_valid   = 1'b1;
            result.bus_write   = 1'b0;
            result.bus_data    = 8'd0;
            result.status      = STATUS_READ;
            state_next.pending = 1'b1;
            state_next.dest    = rd_dest;
        end
    end

endmodule

// File: src/clu_regfile.sv
// ----------------------------------------------------------------------------
// clu_regfile
// Architectural registers A, B..L, SP and the pending load tracking.
// ----------------------------------------------------------------------------
module clu_regfile (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                update,
    input  clu_pkg::clu_state_t state_next,
    output clu_pkg::clu_state_t state
);
    import clu_pkg::*;

    clu_state_t state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (update) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// File: verif/tb_cpu_load_instruction_unit.sv
// ----------------------------------------------------------------------------
// tb_cpu_load_instruction_unit
// Self-checking bench for the load instruction execute unit. A shadow copy of
// the register file predicts status, cycle count, bus access and register
// values for every accepted transfer; a result checker compares each output
// transfer field by field in order. Directed tests cover immediates, stores,
// loads, moves and sequencing errors, then a long random program follows with
// bursty input traffic and a receiver that stalls in several patterns.
// ----------------------------------------------------------------------------
module tb_cpu_load_instruction_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import clu_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int REPORT_LIMIT  = 60;

    typedef struct {
        logic [7:0]  a;
        logic [7:0]  gp [6];
        logic [15:0] sp;
        logic        pending;
        logic [2:0]  dest;
    } cpu_regs_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  cycles;
        logic        bus_valid;
        logic        bus_write;
        logic [15:0] bus_address;
        logic [7:0]  bus_data;
        logic [7:0]  a;
        logic [15:0] bc;
        logic [15:0] de;
        logic [15:0] hl;
        logic [15:0] sp;
    } load_outcome_t;

    typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BLOCKS} rx_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = 1'b0;
    logic [7:0]  s_opcode = 8'd0;
    logic [7:0]  s_imm_low = 8'd0;
    logic [7:0]  s_imm_high = 8'd0;
    logic [7:0]  s_read_data = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [4:0]  m_cycle_count;
    logic        m_bus_valid;
    logic        m_bus_write;
    logic [15:0] m_bus_address;
    logic [7:0]  m_bus_data;
    logic [7:0]  m_value_a;
    logic [15:0] m_value_bc;
    logic [15:0] m_value_de;
    logic [15:0] m_value_hl;
    logic [15:0] m_value_sp;

    cpu_regs_t     cpu_regs;
    load_outcome_t expected_outcomes [$];
    int            errors = 0;
    int            burst_left = 0;
    int            idle_cycles = 0;
    rx_mode_t      rx_mode = RX_ALWAYS;
    int            rx_mode_left = 0;
    logic [7:0]    rx_phase = 8'd0;

    cpu_load_instruction_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_opcode      (s_opcode),
        .s_imm_low     (s_imm_low),
        .s_imm_high    (s_imm_high),
        .s_read_data   (s_read_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_cycle_count (m_cycle_count),
        .m_bus_valid   (m_bus_valid),
        .m_bus_write   (m_bus_write),
        .m_bus_address (m_bus_address),
        .m_bus_data    (m_bus_data),
        .m_value_a     (m_value_a),
        .m_value_bc    (m_value_bc),
        .m_value_de    (m_value_de),
        .m_value_hl    (m_value_hl),
        .m_value_sp    (m_value_sp)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // shadow register file

    function automatic logic [7:0] reg_value(logic [2:0] code);
        if (code == REG_A) begin
            return cpu_regs.a;
        end else if (code < REG_MEM) begin
            return cpu_regs.gp[code];
        end
        return 8'd0;
    endfunction

    function automatic void reg_store(logic [2:0] code, logic [7:0] v);
        if (code == REG_A) begin
            cpu_regs.a = v;
        end else if (code < REG_MEM) begin
            cpu_regs.gp[code] = v;
        end
    endfunction

    function automatic logic [15:0] gp_pair(logic [2:0] hi_code);
        return {cpu_regs.gp[hi_code], cpu_regs.gp[hi_code + 3'd1]};
    endfunction

    function automatic void set_pair(logic [2:0] hi_code, logic [15:0] v);
        cpu_regs.gp[hi_code] = v[15:8];
        cpu_regs.gp[hi_code + 3'd1] = v[7:0];
    endfunction

    function automatic void clear_regs();
        cpu_regs.a = 8'd0;
        foreach (cpu_regs.gp[i]) cpu_regs.gp[i] = 8'd0;
        cpu_regs.sp = 16'd0;
        cpu_regs.pending = 1'b0;
        cpu_regs.dest = REG_B;
    endfunction

    function automatic load_outcome_t execute_load(logic cmd, logic [7:0] op, logic [7:0] lo,
                                                   logic [7:0] hi, logic [7:0] rd);
        load_outcome_t o;
        logic          issue_read;
        logic [2:0]    dst;
        logic [15:0]   hl;
        o = '0;
        issue_read = 1'b0;
        dst = REG_A;
        hl = gp_pair(REG_H);
        if (cmd == CMD_DATA) begin
            if (cpu_regs.pending) begin
                reg_store(cpu_regs.dest, rd);
                cpu_regs.pending = 1'b0;
            end else begin
                o.status = STATUS_SEQ;
            end
        end else if (cpu_regs.pending) begin
            o.status = STATUS_SEQ;
        end else if (op[7:6] == OP_GRP_MOVE && op != OP_HALT) begin
            if (op[5:3] == REG_MEM) begin
                o.bus_valid = 1'b1;
                o.bus_write = 1'b1;
                o.bus_address = hl;
                o.bus_data = reg_value(op[2:0]);
                o.cycles = CYC_8;
            end else if (op[2:0] == REG_MEM) begin
                issue_read = 1'b1;
                dst = op[5:3];
                o.bus_address = hl;
                o.cycles = CYC_8;
            end else begin
                reg_store(op[5:3], reg_value(op[2:0]));
                o.cycles = CYC_4;
            end
        end else begin
            case (op)
                OP_LD_BC_A, OP_LD_DE_A, OP_LDI_HL_A, OP_LDD_HL_A, OP_LDH_N_A, OP_LD_C_A,
                OP_LD_NN_A: begin
                    o.bus_valid = 1'b1;
                    o.bus_write = 1'b1;
                    o.bus_data = cpu_regs.a;
                    o.cycles = CYC_8;
                    case (op)
                        OP_LD_BC_A:  o.bus_address = gp_pair(REG_B);
                        OP_LD_DE_A:  o.bus_address = gp_pair(REG_D);
                        OP_LDI_HL_A: begin
                            o.bus_address = hl;
                            set_pair(REG_H, hl + 16'd1);
                        end
                        OP_LDD_HL_A: begin
                            o.bus_address = hl;
                            set_pair(REG_H, hl - 16'd1);
                        end
                        OP_LDH_N_A: begin
                            o.bus_address = {HIGH_PAGE, lo};
                            o.cycles = CYC_12;
                        end
                        OP_LD_C_A:   o.bus_address = {HIGH_PAGE, cpu_regs.gp[REG_C]};
                        default: begin
                            o.bus_address = {hi, lo};
                            o.cycles = CYC_16;
                        end
                    endcase
                end
                OP_LD_A_BC: begin
                    issue_read = 1'b1;
                    o.bus_address = gp_pair(REG_B);
                    o.cycles = CYC_8;
                end
                OP_LD_A_DE: begin
                    issue_read = 1'b1;
                    o.bus_address = gp_pair(REG_D);
                    o.cycles = CYC_8;
                end
                OP_LDI_A_HL: begin
                    issue_read = 1'b1;
                    o.bus_address = hl;
                    o.cycles = CYC_8;
                    set_pair(REG_H, hl + 16'd1);
                end
                OP_LDD_A_HL: begin
                    issue_read = 1'b1;
                    o.bus_address = hl;
                    o.cycles = CYC_8;
                    set_pair(REG_H, hl - 16'd1);
                end
                OP_LDH_A_N: begin
                    issue_read = 1'b1;
                    o.bus_address = {HIGH_PAGE, lo};
                    o.cycles = CYC_12;
                end
                OP_LD_HL_N: begin
                    o.bus_valid = 1'b1;
                    o.bus_write = 1'b1;
                    o.bus_address = hl;
                    o.bus_data = lo;
                    o.cycles = CYC_12;
                end
                OP_LD_B_N: begin
                    cpu_regs.gp[REG_B] = lo;
                    o.cycles = CYC_8;
                end
                OP_LD_C_N: begin
                    cpu_regs.gp[REG_C] = lo;
                    o.cycles = CYC_8;
                end
                OP_LD_A_N: begin
                    cpu_regs.a = lo;
                    o.cycles = CYC_8;
                end
                OP_LD_BC_NN: begin
                    set_pair(REG_B, {hi, lo});
                    o.cycles = CYC_12;
                end
                OP_LD_HL_NN: begin
                    set_pair(REG_H, {hi, lo});
                    o.cycles = CYC_12;
                end
                OP_LD_SP_NN: begin
                    cpu_regs.sp = {hi, lo};
                    o.cycles = CYC_12;
                end
                default: o.status = STATUS_UNKNOWN;
            endcase
        end
        if (issue_read) begin
            o.bus_valid = 1'b1;
            o.bus_write = 1'b0;
            o.bus_data = 8'd0;
            o.status = STATUS_READ;
            cpu_regs.pending = 1'b1;
            cpu_regs.dest = dst;
        end
        o.a = cpu_regs.a;
        o.bc = gp_pair(REG_B);
        o.de = gp_pair(REG_D);
        o.hl = gp_pair(REG_H);
        o.sp = cpu_regs.sp;
        return o;
    endfunction

    // input side

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic transfer_item(logic cmd, logic [7:0] op, logic [7:0] lo, logic [7:0] hi,
                                 logic [7:0] rd);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_command   <= cmd;
        s_opcode    <= op;
        s_imm_low   <= lo;
        s_imm_high  <= hi;
        s_read_data <= rd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_outcomes.push_back(execute_load(cmd, op, lo, hi, rd));
    endtask

    // output side

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_mode_left <= $urandom_range(32, 256);
            end else begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_ALWAYS: m_ready <= 1'b1;
                RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= (rx_phase[1:0] == 2'b00);
                default:   m_ready <= rx_phase[4];
            endcase
            rx_phase <= rx_phase + 8'd1;
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        load_outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outcomes.size() == 0) begin
                errors++;
                $display("%0t: result transfer with nothing expected", $time);
            end else begin
                want = expected_outcomes.pop_front();
                check_field("status", want.status, m_status);
                check_field("cycle_count", want.cycles, m_cycle_count);
                check_field("bus_valid", want.bus_valid, m_bus_valid);
                check_field("bus_write", want.bus_write, m_bus_write);
                check_field("bus_address", want.bus_address, m_bus_address);
                check_field("bus_data", want.bus_data, m_bus_data);
                check_field("value_a", want.a, m_value_a);
                check_field("value_bc", want.bc, m_value_bc);
                check_field("value_de", want.de, m_value_de);
                check_field("value_hl", want.hl, m_value_hl);
                check_field("value_sp", want.sp, m_value_sp);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // tests

    task automatic test_immediate_loads();
        transfer_item(CMD_EXEC, OP_LD_HL_NN, 8'hFF, 8'hFF, rnd8());
        transfer_item(CMD_EXEC, OP_LD_BC_NN, 8'h00, 8'hFF, rnd8());
        transfer_item(CMD_EXEC, OP_LD_SP_NN, 8'hFF, 8'hFF, rnd8());
        transfer_item(CMD_EXEC, OP_LD_A_N, 8'hFF, rnd8(), rnd8());
        transfer_item(CMD_EXEC, OP_LD_B_N, 8'h00, rnd8(), rnd8());
        transfer_item(CMD_EXEC, OP_LD_C_N, 8'hFF, rnd8(), rnd8());
    endtask

    task automatic test_memory_stores();
        // hl wraps both ways
        transfer_item(CMD_EXEC, OP_LDI_HL_A, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_EXEC, OP_LDD_HL_A, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_EXEC, OP_LD_C_A, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_EXEC, OP_LD_NN_A, 8'h00, 8'h00, rnd8());
        transfer_item(CMD_EXEC, OP_LD_HL_N, 8'h5A, rnd8(), rnd8());
        transfer_item(CMD_EXEC, {OP_GRP_MOVE, REG_MEM, REG_B}, rnd8(), rnd8(), rnd8());
    endtask

    task automatic test_memory_loads();
        transfer_item(CMD_EXEC, OP_LDH_A_N, 8'hFF, rnd8(), rnd8());
        transfer_item(CMD_DATA, rnd8(), rnd8(), rnd8(), 8'h00);
        transfer_item(CMD_EXEC, OP_LDI_A_HL, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_DATA, rnd8(), rnd8(), rnd8(), 8'hFF);
        transfer_item(CMD_EXEC, {OP_GRP_MOVE, REG_H, REG_MEM}, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_DATA, rnd8(), rnd8(), rnd8(), 8'hA5);
    endtask

    task automatic test_register_moves();
        transfer_item(CMD_EXEC, {OP_GRP_MOVE, REG_B, REG_A}, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_EXEC, {OP_GRP_MOVE, REG_A, REG_A}, rnd8(), rnd8(), rnd8());
    endtask

    task automatic test_sequence_errors();
        transfer_item(CMD_EXEC, OP_HALT, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_EXEC, 8'hFF, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_DATA, rnd8(), rnd8(), rnd8(), rnd8());
        transfer_item(CMD_EXEC, OP_LD_A_DE, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_EXEC, OP_LD_A_N, rnd8(), rnd8(), rnd8());
        transfer_item(CMD_DATA, rnd8(), rnd8(), rnd8(), rnd8());
    endtask

    function automatic logic [7:0] subset_opcode(int idx);
        case (idx)
            0:       return OP_LD_BC_A;
            1:       return OP_LD_DE_A;
            2:       return OP_LDI_HL_A;
            3:       return OP_LDD_HL_A;
            4:       return OP_LD_A_BC;
            5:       return OP_LD_A_DE;
            6:       return OP_LDI_A_HL;
            7:       return OP_LDD_A_HL;
            8:       return OP_LDH_A_N;
            9:       return OP_LDH_N_A;
            10:      return OP_LD_C_A;
            11:      return OP_LD_NN_A;
            12:      return OP_LD_HL_N;
            13:      return OP_LD_B_N;
            14:      return OP_LD_C_N;
            15:      return OP_LD_A_N;
            16:      return OP_LD_BC_NN;
            17:      return OP_LD_HL_NN;
            18:      return OP_LD_SP_NN;
            default: return OP_HALT;
        endcase
    endfunction

    task automatic test_random_program();
        int         executed;
        int         pick;
        logic [5:0] operands;
        logic [7:0] op;
        executed = 0;
        while (executed < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (cpu_regs.pending) begin
                if (pick < 85) begin
                    transfer_item(CMD_DATA, rnd8(), rnd8(), rnd8(), rnd8());
                    executed++;
                end else begin
                    transfer_item(CMD_EXEC, rnd8(), rnd8(), rnd8(), rnd8());
                end
            end else if (pick < 5) begin
                transfer_item(CMD_DATA, rnd8(), rnd8(), rnd8(), rnd8());
            end else begin
                if (pick < 50) begin
                    operands = 6'($urandom_range(0, 63));
                    op = {OP_GRP_MOVE, operands};
                end else if (pick < 90) begin
                    op = subset_opcode($urandom_range(0, 19));
                end else begin
                    op = rnd8();
                end
                transfer_item(CMD_EXEC, op, rnd8(), rnd8(), rnd8());
                executed++;
            end
        end
    endtask

    initial begin
        clear_regs();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_immediate_loads();
        test_memory_stores();
        test_memory_loads();
        test_register_moves();
        test_sequence_errors();
        test_random_program();
        s_valid <= 1'b0;
        while (expected_outcomes.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: cpu_load_instruction_unit.f
src/clu_pkg.sv
src/clu_exec.sv
src/clu_regfile.sv
src/cpu_load_instruction_unit.sv
verif/tb_cpu_load_instruction_unit.sv
